// ----- sv/line_pixel_stepper_macros.svh -----
// assertion macros shared by the line pixel stepper rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef LINE_PIXEL_STEPPER_MACROS_SVH
`define LINE_PIXEL_STEPPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line_pixel_stepper: same-cycle check failed");

// next-cycle implication, checked out of reset
`define LPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line_pixel_stepper: next-cycle check failed");

`endif

// ----- sv/lps_pkg.sv -----
// types and constants for the line pixel stepper
// no dependencies
`default_nettype none

package lps_pkg;

  localparam int unsigned COLOR_BITS = 24;

  // command carried in the input tuser bit
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // line classification
  typedef enum logic [1:0] {
    MODE_SHALLOW = 2'd0,
    MODE_STEEP   = 2'd1,
    MODE_DIAG    = 2'd2
  } mode_e;

endpackage

`default_nettype wire

// ----- sv/line_pixel_stepper.sv -----
// line pixel stepper: line rasterizer, 4-connected but for diagonal lines, one output item per input item
// depends on lps_pkg and line_pixel_stepper_macros.svh
//
//  channel   dir  tdata (low bit up)                      tuser        tlast
//  s_axis    in   x_start y_start x_end y_end pen_color   cmd          -
//  m_axis    out  pixel_x pixel_y pixel_color             pixel_valid  last_pixel
//
//  one item per cycle while s_axis_tready_o is high: an accepted item updates the line
//  state and its pixel lands in the output register at the same edge, or in the skid
//  stage if the output is stalled; the err add and compare sets the clock period
//  reset clears the line state to idle and empties the output stages
//  a two-deep output (register plus skid) keeps s_axis_tready_o a register:
//  it drops only when both output stages hold items
`default_nettype none
`include "line_pixel_stepper_macros.svh"

module line_pixel_stepper #(
  parameter int unsigned COORD_BITS = 11
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input item channel
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // x_start, y_start, x_end, y_end, pen_color
  input  wire logic [((4*COORD_BITS+lps_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  wire logic                s_axis_tuser_i,
  // result item channel
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color
  output logic [((2*COORD_BITS+lps_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // pixel_valid
  output logic                     m_axis_tuser_o,
  // last_pixel
  output logic                     m_axis_tlast_o
);

  import lps_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned IN_W  = ((4*CB+COLOR_BITS+7)/8)*8;
  localparam int unsigned OUT_W = ((2*CB+COLOR_BITS+7)/8)*8;
  localparam logic [CB-1:0] ONE_C = CB'(1);
  localparam logic [CB:0]   ONE_S = (CB+1)'(1);

  // coordinate step with wraparound
  function automatic logic [CB-1:0] move_c(input logic [CB-1:0] c, input logic neg);
    return neg ? (c - ONE_C) : (c + ONE_C);
  endfunction

  // line state
  logic [CB-1:0]         cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CB+1:0]         err_q, err_d;
  logic [CB:0]           steps_q, steps_d;
  logic [CB-1:0]         adx_q, adx_d, ady_q, ady_d;
  logic                  xneg_q, xneg_d, yneg_q, yneg_d;
  mode_e                 mode_q, mode_d;
  logic                  minor_q, minor_d;
  logic                  active_q, active_d;
  logic [COLOR_BITS-1:0] color_q, color_d;

  // result of the accepted item
  logic                  res_vld, res_last;
  logic [CB-1:0]         res_x, res_y;
  logic [COLOR_BITS-1:0] res_color;
  logic [OUT_W-1:0]      res_data;

  // input fields
  logic [CB-1:0]         xs, ys, xe, ye;
  logic [COLOR_BITS-1:0] pen;
  assign xs  = s_axis_tdata_i[0*CB +: CB];
  assign ys  = s_axis_tdata_i[1*CB +: CB];
  assign xe  = s_axis_tdata_i[2*CB +: CB];
  assign ye  = s_axis_tdata_i[3*CB +: CB];
  assign pen = s_axis_tdata_i[4*CB +: COLOR_BITS];

  // handshakes
  logic in_fire, out_fire;
  logic out_vld_q, skid_vld_q;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_vld_q && m_axis_tready_i;

  // start path terms
  logic          st_xneg, st_yneg;
  logic [CB-1:0] st_adx, st_ady, st_major;
  logic [CB:0]   st_sum;
  // step path terms
  logic [CB-1:0] major, minor;
  logic [CB+1:0] acc, two_major;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    err_d    = err_q;
    steps_d  = steps_q;
    adx_d    = adx_q;
    ady_d    = ady_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    mode_d   = mode_q;
    minor_d  = minor_q;
    active_d = active_q;
    color_d  = color_q;

    res_vld   = 1'b0;
    res_last  = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_color = '0;

    // start: classify the line
    st_xneg  = (xe < xs);
    st_yneg  = (ye < ys);
    st_adx   = st_xneg ? (xs - xe) : (xe - xs);
    st_ady   = st_yneg ? (ys - ye) : (ye - ys);
    st_sum   = {1'b0, st_adx} + {1'b0, st_ady};
    st_major = (st_ady > st_adx) ? st_ady : st_adx;

    // step: error accumulate and compare against twice the major delta
    major     = (mode_q == MODE_STEEP) ? ady_q : adx_q;
    minor     = (mode_q == MODE_STEEP) ? adx_q : ady_q;
    acc       = err_q + {1'b0, minor, 1'b0};
    two_major = {1'b0, major, 1'b0};

    if (s_axis_tuser_i == CMD_START) begin
      color_d = pen;
      cur_x_d = xs;
      cur_y_d = ys;
      xneg_d  = st_xneg;
      yneg_d  = st_yneg;
      adx_d   = st_adx;
      ady_d   = st_ady;
      minor_d = 1'b0;
      if (st_adx == st_ady) begin
        mode_d  = MODE_DIAG;
        steps_d = {1'b0, st_adx};
      end else if (st_ady > st_adx) begin
        mode_d  = MODE_STEEP;
        steps_d = st_sum;
      end else begin
        mode_d  = MODE_SHALLOW;
        steps_d = st_sum;
      end
      err_d     = {2'b00, st_major};
      active_d  = (steps_d != '0);
      res_vld   = 1'b1;
      res_x     = xs;
      res_y     = ys;
      res_color = pen;
      res_last  = !active_d;
    end else if (active_q) begin
      unique case (mode_q)
        MODE_DIAG: begin
          cur_x_d = move_c(cur_x_q, xneg_q);
          cur_y_d = move_c(cur_y_q, yneg_q);
        end
        MODE_STEEP, MODE_SHALLOW: begin
          if (minor_q) begin
            // minor-axis only step keeps the line 4-connected
            if (mode_q == MODE_STEEP) cur_x_d = move_c(cur_x_q, xneg_q);
            else                      cur_y_d = move_c(cur_y_q, yneg_q);
            minor_d = 1'b0;
          end else begin
            if (mode_q == MODE_STEEP) cur_y_d = move_c(cur_y_q, yneg_q);
            else                      cur_x_d = move_c(cur_x_q, xneg_q);
            if (acc >= two_major) begin
              err_d   = acc - two_major;
              minor_d = 1'b1;
            end else begin
              err_d = acc;
            end
          end
        end
        default: ;
      endcase
      steps_d = steps_q - ONE_S;
      if (steps_d == '0) begin
        active_d = 1'b0;
        minor_d  = 1'b0;
      end
      res_vld   = 1'b1;
      res_x     = cur_x_d;
      res_y     = cur_y_d;
      res_color = color_q;
      res_last  = (steps_d == '0);
    end
  end

  assign res_data = OUT_W'({res_color, res_y, res_x});

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      err_q    <= '0;
      steps_q  <= '0;
      adx_q    <= '0;
      ady_q    <= '0;
      xneg_q   <= 1'b0;
      yneg_q   <= 1'b0;
      mode_q   <= MODE_SHALLOW;
      minor_q  <= 1'b0;
      active_q <= 1'b0;
      color_q  <= '0;
    end else if (in_fire) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      err_q    <= err_d;
      steps_q  <= steps_d;
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      xneg_q   <= xneg_d;
      yneg_q   <= yneg_d;
      mode_q   <= mode_d;
      minor_q  <= minor_d;
      active_q <= active_d;
      color_q  <= color_d;
    end
  end

  // output register and skid stage
  logic [OUT_W-1:0] out_data_q, skid_data_q;
  logic             out_user_q, out_last_q, skid_user_q, skid_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_vld_q && !m_axis_tready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
        out_last_q <= skid_last_q;
      end
    end else if (in_fire) begin
      if (out_vld_q && !m_axis_tready_i) begin
        skid_data_q <= res_data;
        skid_user_q <= res_vld;
        skid_last_q <= res_last;
      end else begin
        out_data_q <= res_data;
        out_user_q <= res_vld;
        out_last_q <= res_last;
      end
    end
  end

  assign s_axis_tready_o = !skid_vld_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // skid holds an item only behind a full output register
  `LPS_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q)
  // an item arriving at a stalled full output goes to the skid stage
  `LPS_ASSERT_NXT(a_skid_fill, in_fire && out_vld_q && !m_axis_tready_i, skid_vld_q)
  // active line exactly while steps remain
  `LPS_ASSERT_IMP(a_active_steps, 1'b1, active_q == (steps_q != '0))
  // no pending minor step once the line is done
  `LPS_ASSERT_IMP(a_idle_no_minor, !active_q, !minor_q)
  // error term stays below twice the major delta
  `LPS_ASSERT_IMP(a_err_bound, active_q && (mode_q != MODE_DIAG), err_q < two_major)

endmodule

`default_nettype wire

// ----- dv/tb_line_pixel_stepper.sv -----
// testbench for line_pixel_stepper: start and step items driven with random gaps,
// every pixel item checked in order against a predictor kept inside this file
// depends on lps_pkg and the line_pixel_stepper rtl
`timescale 1ns / 100ps

module tb_line_pixel_stepper;
  import lps_pkg::*;

  localparam int unsigned CW = 11;
  localparam int unsigned S_W = ((4*CW+COLOR_BITS+7)/8)*8;
  localparam int unsigned M_W = ((2*CW+COLOR_BITS+7)/8)*8;
  localparam int unsigned COORD_MAX = (1 << CW) - 1;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [CW-1:0]         xs;
    logic [CW-1:0]         ys;
    logic [CW-1:0]         xe;
    logic [CW-1:0]         ye;
    logic [COLOR_BITS-1:0] color;
  } line_req_t;

  typedef struct packed {
    logic                  valid;
    logic [CW-1:0]         x;
    logic [CW-1:0]         y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid_i = 1'b0;
  logic           s_axis_tready_o;
  logic [S_W-1:0] s_axis_tdata_i = '0;
  logic           s_axis_tuser_i = 1'b0;
  logic           m_axis_tvalid_o;
  logic           m_axis_tready_i = 1'b0;
  logic [M_W-1:0] m_axis_tdata_o;
  logic           m_axis_tuser_o;
  logic           m_axis_tlast_o;

  line_pixel_stepper #(
    .COORD_BITS(CW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the line state
  logic [CW-1:0]         ln_x, ln_y;
  logic [CW-1:0]         dx_mag, dy_mag;
  logic                  x_down, y_down;
  logic [13:0]           err_acc;
  logic [11:0]           steps_rem;
  mode_e                 ln_mode;
  logic                  minor_due;
  logic                  ln_busy;
  logic [COLOR_BITS-1:0] ln_color;

  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     items_sent = 0;
  int     pixels_checked = 0;
  int     lines_started = 0;
  int     quiet_cycles = 0;
  bit     idle_on = 1'b1;
  pixel_t seen, want_px;

  function automatic logic [CW-1:0] nudge(logic [CW-1:0] c, logic down);
    return down ? c - 1'b1 : c + 1'b1;
  endfunction

  // advances the predicted line by one item and returns the pixel it produces
  function automatic pixel_t raster_next(cmd_e cmd, line_req_t req);
    logic [CW-1:0] major, minor;
    logic          steep;
    pixel_t        px;
    px = '0;
    if (cmd == CMD_START) begin
      ln_color  = req.color;
      ln_x      = req.xs;
      ln_y      = req.ys;
      x_down    = req.xe < req.xs;
      y_down    = req.ye < req.ys;
      dx_mag    = x_down ? req.xs - req.xe : req.xe - req.xs;
      dy_mag    = y_down ? req.ys - req.ye : req.ye - req.ys;
      minor_due = 1'b0;
      if (dx_mag == dy_mag) begin
        ln_mode   = MODE_DIAG;
        steps_rem = {1'b0, dx_mag};
        major     = dx_mag;
      end else if (dy_mag > dx_mag) begin
        ln_mode   = MODE_STEEP;
        steps_rem = {1'b0, dx_mag} + {1'b0, dy_mag};
        major     = dy_mag;
      end else begin
        ln_mode   = MODE_SHALLOW;
        steps_rem = {1'b0, dx_mag} + {1'b0, dy_mag};
        major     = dx_mag;
      end
      // accumulator starts at one half of the scaled range
      err_acc = {3'b0, major};
      ln_busy = steps_rem != 0;
      px = '{1'b1, ln_x, ln_y, ln_color, !ln_busy};
      return px;
    end
    // step with nothing to draw: empty item
    if (!ln_busy) return px;
    if (ln_mode == MODE_DIAG) begin
      ln_x = nudge(ln_x, x_down);
      ln_y = nudge(ln_y, y_down);
    end else begin
      steep = ln_mode == MODE_STEEP;
      major = steep ? dy_mag : dx_mag;
      minor = steep ? dx_mag : dy_mag;
      if (minor_due) begin
        if (steep) ln_x = nudge(ln_x, x_down);
        else ln_y = nudge(ln_y, y_down);
        minor_due = 1'b0;
      end else begin
        if (steep) ln_y = nudge(ln_y, y_down);
        else ln_x = nudge(ln_x, x_down);
        err_acc = err_acc + {2'b0, minor, 1'b0};
        if (err_acc >= {2'b0, major, 1'b0}) begin
          err_acc   = err_acc - {2'b0, major, 1'b0};
          minor_due = 1'b1;
        end
      end
    end
    steps_rem = steps_rem - 1'b1;
    px = '{1'b1, ln_x, ln_y, ln_color, 1'b0};
    if (steps_rem == 0) begin
      ln_busy   = 1'b0;
      minor_due = 1'b0;
      px.last   = 1'b1;
    end
    return px;
  endfunction

  function automatic int gap_draw();
    return idle_on ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic line_req_t rand_req();
    line_req_t r;
    r.xs    = CW'($urandom_range(0, COORD_MAX));
    r.ys    = CW'($urandom_range(0, COORD_MAX));
    r.xe    = CW'($urandom_range(0, COORD_MAX));
    r.ye    = CW'($urandom_range(0, COORD_MAX));
    r.color = COLOR_BITS'($urandom);
    return r;
  endfunction

  // moves c by d in a random direction, staying inside the coordinate range
  function automatic logic [CW-1:0] offset_coord(int c, int d);
    if ((($urandom_range(0, 1) == 1) && (c + d <= COORD_MAX)) || (c < d)) return CW'(c + d);
    return CW'(c - d);
  endfunction

  task automatic send_item(cmd_e cmd, line_req_t req);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= S_W'({req.color, req.ye, req.xe, req.ys, req.xs});
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    pending_pixels.push_back(raster_next(cmd, req));
    items_sent++;
    if (cmd == CMD_START) lines_started++;
  endtask

  // one start item followed by n step items with junk payloads
  task automatic draw_line(line_req_t req, int n);
    send_item(CMD_START, req);
    repeat (n) send_item(CMD_STEP, rand_req());
  endtask

  task automatic test_directed();
    // step before any line was started
    send_item(CMD_STEP, '1);
    // point lines at both corners, then a step on an idle block
    draw_line('{11'd0, 11'd0, 11'd0, 11'd0, 24'h000000}, 1);
    draw_line('{11'd2047, 11'd2047, 11'd2047, 11'd2047, 24'hffffff}, 0);
    // shallow, steep with x going down, diagonal away from the corner
    draw_line('{11'd0, 11'd0, 11'd4, 11'd1, 24'h123456}, 5);
    draw_line('{11'd10, 11'd10, 11'd9, 11'd13, 24'habcdef}, 4);
    draw_line('{11'd2047, 11'd0, 11'd2045, 11'd2, 24'h00ff00}, 2);
    // full-span diagonal abandoned by the next start
    draw_line('{11'd0, 11'd2047, 11'd2047, 11'd0, 24'hff00ff}, 2);
    // vertical line run past its end
    draw_line('{11'd5, 11'd5, 11'd5, 11'd0, 24'h800000}, 6);
  endtask

  task automatic random_line();
    line_req_t req;
    int kind, span, d, dx, dy, full, n;
    kind = $urandom_range(0, 15);
    req  = rand_req();
    if (kind == 0) begin
      // stray steps
      repeat ($urandom_range(1, 3)) send_item(CMD_STEP, rand_req());
      return;
    end
    if (kind == 1) begin
      // long line anywhere on the grid, cut short
      draw_line(req, $urandom_range(1, 8));
      return;
    end
    span = (kind == 2) ? 0 : ((kind == 4) ? 60 : 12);
    if (kind == 3) begin
      d = $urandom_range(1, 20);
      req.xe = offset_coord(int'(req.xs), d);
      req.ye = offset_coord(int'(req.ys), d);
    end else begin
      req.xe = offset_coord(int'(req.xs), $urandom_range(0, span));
      req.ye = offset_coord(int'(req.ys), $urandom_range(0, span));
    end
    dx   = (req.xe > req.xs) ? int'(req.xe - req.xs) : int'(req.xs - req.xe);
    dy   = (req.ye > req.ys) ? int'(req.ye - req.ys) : int'(req.ys - req.ye);
    full = (dx == dy) ? dx : dx + dy;
    n    = full + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, full);
    draw_line(req, n);
  endtask

  task automatic test_random();
    int stop_at, next_phase;
    stop_at    = items_sent + RANDOM_ITEMS;
    next_phase = items_sent;
    while (items_sent < stop_at) begin
      // random stretches with or without idling on both sides
      if (items_sent >= next_phase) begin
        idle_on    = $urandom_range(0, 3) != 0;
        next_phase = items_sent + 150;
      end
      random_line();
    end
  endtask

  // receiver: random stall before each item, ready held until it moves
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = gap_draw();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  task automatic note_mismatch(string what, pixel_t want, pixel_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): want v=%0b x=%0d y=%0d c=%06h l=%0b",
                " got v=%0b x=%0d y=%0d c=%06h l=%0b"},
               what, want.valid, want.x, want.y, want.color, want.last,
               got.valid, got.x, got.y, got.color, got.last);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen = '{m_axis_tuser_o, m_axis_tdata_o[CW-1:0], m_axis_tdata_o[2*CW-1:CW],
               m_axis_tdata_o[2*CW+COLOR_BITS-1:2*CW], m_axis_tlast_o};
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected", '0, seen);
      end else begin
        want_px = pending_pixels.pop_front();
        if (seen.valid !== want_px.valid || seen.x !== want_px.x || seen.y !== want_px.y ||
            seen.color !== want_px.color || seen.last !== want_px.last)
          note_mismatch("pixel", want_px, seen);
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d items over %0d lines, %0d pixel items checked",
             items_sent, lines_started, pixels_checked);
    $display("%0d mismatches seen", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
